>>> rtl/wad_pkg.sv
package wad_pkg;

  localparam int ZG_W      = 10;
  localparam int LIMIT_W   = 22;
  localparam int SPREAD_W  = 56;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_ZERO_G       = 1'b0;
  localparam logic [CFG_ADDR_W-3:0] REG_SPREAD_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQX,
    OP_SQY,
    OP_SQZ,
    OP_ACC,
    OP_E2,
    OP_O2,
    OP_SS,
    OP_LIM,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ram_rd;
    logic ram_wr;
  } cmd_t;

endpackage

>>> rtl/wad_ram.sv
module wad_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/wad_regs.sv
module wad_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wad_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wad_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wad_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [wad_pkg::ZG_W-1:0]          zero_g_level,
  output logic [wad_pkg::LIMIT_W-1:0]       spread_limit
);

  logic [wad_pkg::CFG_ADDR_W-3:0] reg_sel;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[wad_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_g_level <= '0;
      spread_limit <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        wad_pkg::REG_ZERO_G:       zero_g_level <= pwdata[wad_pkg::ZG_W-1:0];
        wad_pkg::REG_SPREAD_LIMIT: spread_limit <= pwdata[wad_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      wad_pkg::REG_ZERO_G:       prdata = wad_pkg::CFG_DATA_W'(zero_g_level);
      wad_pkg::REG_SPREAD_LIMIT: prdata = wad_pkg::CFG_DATA_W'(spread_limit);
      default:                   prdata = '0;
    endcase
  end

endmodule

>>> rtl/wad_ctrl.sv
module wad_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output wad_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQZ,
    S_ACC,
    S_E2,
    S_O2,
    S_SS,
    S_LIM,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_tready = (state == S_IDLE);
  assign out_free  = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_tvalid <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_tvalid) state <= S_SQX;
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_SQZ;
        S_SQZ:  state <= S_ACC;
        S_ACC:  state <= S_E2;
        S_E2:   state <= S_O2;
        S_O2:   state <= S_SS;
        S_SS:   state <= S_LIM;
        S_LIM:  state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.op     = wad_pkg::OP_NONE;
    cmd.ram_rd = 1'b0;
    cmd.ram_wr = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op     = wad_pkg::OP_LOAD;
          cmd.ram_rd = 1'b1;
        end
      end
      S_SQX: cmd.op = wad_pkg::OP_SQX;
      S_SQY: cmd.op = wad_pkg::OP_SQY;
      S_SQZ: cmd.op = wad_pkg::OP_SQZ;
      S_ACC: cmd.op = wad_pkg::OP_ACC;
      S_E2: begin
        cmd.op     = wad_pkg::OP_E2;
        cmd.ram_wr = 1'b1;
      end
      S_O2:  cmd.op = wad_pkg::OP_O2;
      S_SS:  cmd.op = wad_pkg::OP_SS;
      S_LIM: cmd.op = wad_pkg::OP_LIM;
      S_OUT: if (out_free) cmd.op = wad_pkg::OP_OUT;
      default: ;
    endcase
  end

endmodule

>>> rtl/wad_dpath.sv
module wad_dpath #(
  parameter int WINDOW_LEN  = 80,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wad_pkg::cmd_t                   cmd,
  input  logic [SAMPLE_BITS-1:0]          accel_x,
  input  logic [SAMPLE_BITS-1:0]          accel_y,
  input  logic [SAMPLE_BITS-1:0]          accel_z,
  input  logic [wad_pkg::ZG_W-1:0]        zero_g_level,
  input  logic [wad_pkg::LIMIT_W-1:0]     spread_limit,
  output logic                            walking,
  output logic [wad_pkg::SPREAD_W-1:0]    window_spread
);

  localparam int MAG_W    = (SAMPLE_BITS > wad_pkg::ZG_W) ? SAMPLE_BITS : wad_pkg::ZG_W;
  localparam int ENERGY_W = 2 * MAG_W + 2;
  localparam int NW       = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W   = $clog2(WINDOW_LEN);
  localparam int SUM_W    = ENERGY_W + NW;
  localparam int SQSUM_W  = 2 * ENERGY_W + NW;
  localparam int LIM_W    = wad_pkg::LIMIT_W + NW;
  localparam int MUL_W    = SUM_W;
  localparam int PROD_W   = 2 * MUL_W;

  logic [SAMPLE_BITS-1:0] ax, ay, az;
  logic [ENERGY_W-1:0]    energy;
  logic [ENERGY_W-1:0]    old_e;
  logic [SUM_W-1:0]       sum;
  logic [SQSUM_W-1:0]     sumsq;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      a_reg;
  logic [PROD_W-1:0]      b_reg;
  logic [SLOT_W-1:0]      slot;
  logic                   wrapped;
  logic [ENERGY_W-1:0]    ram_rdata;

  logic [SAMPLE_BITS-1:0] axis_raw;
  logic signed [MAG_W:0]  diff;
  logic [MAG_W-1:0]       mag;
  logic [LIM_W-1:0]       lim;
  logic [MUL_W-1:0]       mul_a;
  logic [PROD_W-1:0]      mul_p;
  logic [PROD_W-1:0]      spread;

  wad_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .waddr (slot),
    .wdata (energy),
    .re    (cmd.ram_rd),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (cmd.op)
      wad_pkg::OP_SQY: axis_raw = ay;
      wad_pkg::OP_SQZ: axis_raw = az;
      default:         axis_raw = ax;
    endcase
  end

  assign diff = $signed({1'b0, MAG_W'(axis_raw)}) - $signed({1'b0, MAG_W'(zero_g_level)});
  assign mag  = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
  assign lim  = LIM_W'(spread_limit) * LIM_W'(WINDOW_LEN);

  always_comb begin
    unique case (cmd.op)
      wad_pkg::OP_SQX,
      wad_pkg::OP_SQY,
      wad_pkg::OP_SQZ: mul_a = MUL_W'(mag);
      wad_pkg::OP_E2:  mul_a = MUL_W'(energy);
      wad_pkg::OP_O2:  mul_a = MUL_W'(old_e);
      wad_pkg::OP_SS:  mul_a = sum;
      wad_pkg::OP_LIM: mul_a = MUL_W'(lim);
      default:         mul_a = '0;
    endcase
  end

  assign mul_p  = PROD_W'(mul_a) * PROD_W'(mul_a);
  assign spread = (a_reg >= b_reg) ? a_reg - b_reg : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      wrapped <= 1'b0;
      sum     <= '0;
      sumsq   <= '0;
    end else begin
      unique case (cmd.op)
        wad_pkg::OP_E2: begin
          sum <= sum - SUM_W'(old_e) + SUM_W'(energy);
          if (slot == SLOT_W'(WINDOW_LEN - 1)) begin
            slot    <= '0;
            wrapped <= 1'b1;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        wad_pkg::OP_O2: sumsq <= sumsq + prod[SQSUM_W-1:0];
        wad_pkg::OP_SS: sumsq <= sumsq - prod[SQSUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      wad_pkg::OP_LOAD: begin
        ax <= accel_x;
        ay <= accel_y;
        az <= accel_z;
      end
      wad_pkg::OP_SQX: begin
        prod  <= mul_p;
        old_e <= wrapped ? ram_rdata : '0;
      end
      wad_pkg::OP_SQY: begin
        prod   <= mul_p;
        energy <= prod[ENERGY_W-1:0];
      end
      wad_pkg::OP_SQZ: begin
        prod   <= mul_p;
        energy <= energy + prod[ENERGY_W-1:0];
      end
      wad_pkg::OP_ACC: energy <= energy + prod[ENERGY_W-1:0];
      wad_pkg::OP_E2,
      wad_pkg::OP_O2,
      wad_pkg::OP_SS:  prod <= mul_p;
      wad_pkg::OP_LIM: begin
        prod  <= mul_p;
        b_reg <= prod;
        a_reg <= PROD_W'(sumsq) * PROD_W'(WINDOW_LEN);
      end
      wad_pkg::OP_OUT: begin
        walking <= (spread > prod);
        if (|spread[PROD_W-1:wad_pkg::SPREAD_W]) begin
          window_spread <= '1;
        end else begin
          window_spread <= spread[wad_pkg::SPREAD_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/walking_activity_detector.sv
// walking activity detector
// one 3-axis accelerometer sample enters per input word on the in_ stream;
// the zero-g level is removed per axis and the squared offsets are summed
// into an energy value that enters a WINDOW_LEN-deep circular window.
// each word yields one result word on the out_ stream: the window spread
// (N*sum of squares - squared sum) in tdata and the walking flag in tuser,
// set when the spread exceeds (N*spread_limit)^2.
// zero_g_level and spread_limit are written over the apb port at byte
// addresses 0 and 4; the user must write them only while the block is
// idle; the block has no check for this. a new word is taken only once
// the last is through all steps, since the single shared multiplier
// computes three axis squares, two energy squares, the squared sum and
// the squared limit in turn, plus one window memory read and write.
// reset empties the window (it reads as zeros until first written around)
// and clears the sums, the config registers and both handshakes.
// a stalled receiver holds the result; the next input word is still taken
// and worked on, and waits in the last step until the output is free.
module walking_activity_detector #(
  parameter int WINDOW_LEN  = 80,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // accel_x, accel_y, accel_z
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // window_spread
  output logic [wad_pkg::SPREAD_W-1:0]      out_tdata,
  // walking
  output logic                              out_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wad_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [wad_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [wad_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  wad_pkg::cmd_t                 cmd;
  logic [wad_pkg::ZG_W-1:0]      zero_g_level;
  logic [wad_pkg::LIMIT_W-1:0]   spread_limit;

  wad_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .zero_g_level (zero_g_level),
    .spread_limit (spread_limit)
  );

  wad_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  wad_dpath #(
    .WINDOW_LEN  (WINDOW_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .accel_x       (in_tdata[SAMPLE_BITS-1:0]),
    .accel_y       (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .accel_z       (in_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .zero_g_level  (zero_g_level),
    .spread_limit  (spread_limit),
    .walking       (out_tuser),
    .window_spread (out_tdata)
  );

endmodule

>>> rtl/wad_chk.sv
module wad_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [wad_pkg::SPREAD_W-1:0] out_tdata,
  input logic                         out_tuser
);

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // one word at a time: input closes right after a word is taken
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

  // a result never appears right after the word that causes it
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result too early");

  // zero spread can never pass the limit
  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_tvalid && (out_tdata == '0) |-> !out_tuser)
    else $error("walking set with zero spread");

endmodule

bind walking_activity_detector wad_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> verif/walking_activity_detector_tb.sv
`timescale 1ns / 1ps

module walking_activity_detector_tb;

  localparam int WINDOW_LEN = 80;
  localparam int SAMPLE_W   = 10;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam logic [63:0] SPREAD_MAX = (64'd1 << wad_pkg::SPREAD_W) - 64'd1;

  typedef struct packed {
    logic                         walking;
    logic [wad_pkg::SPREAD_W-1:0] spread;
  } activity_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  // accel_x, accel_y, accel_z
  logic [31:0]                    in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // window_spread
  logic [wad_pkg::SPREAD_W-1:0]   out_tdata;
  // walking
  logic                           out_tuser;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [wad_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [wad_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [wad_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  walking_activity_detector uut (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0]     sample_words[$];
  activity_t       pending_results[$];
  int              send_idle_pct = 0;
  int              sink_stall_pct = 0;
  bit              failed = 1'b0;

  logic [wad_pkg::ZG_W-1:0]    zero_g_cfg = '0;
  logic [wad_pkg::LIMIT_W-1:0] limit_cfg = '0;
  logic [21:0]        energy_hist [WINDOW_LEN] = '{default: '0};
  int                 hist_slot = 0;
  logic [63:0]        energy_total = '0;
  logic [63:0]        energy_sq_total = '0;

  function automatic logic [63:0] offset_square(input logic [SAMPLE_W-1:0] raw);
    int d;
    d = int'(raw) - int'(zero_g_cfg);
    return 64'(d * d);
  endfunction

  function automatic logic [31:0] pack_sample(input int x, input int y, input int z);
    return {2'b00, 10'(z), 10'(y), 10'(x)};
  endfunction

  function automatic int near_zero_g(input int amp);
    int v;
    v = int'(zero_g_cfg) + int'($urandom_range(2 * amp, 0)) - amp;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (sample_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= sample_words.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    activity_t   want;
    logic [63:0] energy;
    logic [63:0] old;
    logic [63:0] scaled;
    logic [63:0] sq;
    logic [63:0] spread;
    logic [63:0] lim;
    if (!rst) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected word, expected none, got spread %0d walking %0b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.walking) begin
            failed = 1'b1;
            $display("%0t: walking mismatch, expected %0b, got %0b",
                     $time, want.walking, out_tuser);
          end
          if (out_tdata !== want.spread) begin
            failed = 1'b1;
            $display("%0t: spread mismatch, expected %0d, got %0d",
                     $time, want.spread, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        energy = offset_square(in_tdata[9:0]) + offset_square(in_tdata[19:10])
                 + offset_square(in_tdata[29:20]);
        old = 64'(energy_hist[hist_slot]);
        energy_total = energy_total - old + energy;
        energy_sq_total = energy_sq_total - old * old + energy * energy;
        energy_hist[hist_slot] = energy[21:0];
        hist_slot = (hist_slot == WINDOW_LEN - 1) ? 0 : hist_slot + 1;
        scaled = 64'(WINDOW_LEN) * energy_sq_total;
        sq = energy_total * energy_total;
        spread = (scaled >= sq) ? scaled - sq : 64'd0;
        lim = 64'(WINDOW_LEN) * 64'(limit_cfg);
        want.walking = (spread > lim * lim);
        want.spread = (spread > SPREAD_MAX) ? '1 : spread[wad_pkg::SPREAD_W-1:0];
        pending_results.push_back(want);
      end
    end
  end

  task automatic cfg_write(input logic [wad_pkg::CFG_ADDR_W-3:0] reg_idx,
                           input logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_idx == wad_pkg::REG_ZERO_G) begin
      zero_g_cfg = value[wad_pkg::ZG_W-1:0];
      readback = 32'(value[wad_pkg::ZG_W-1:0]);
    end else begin
      limit_cfg = value[wad_pkg::LIMIT_W-1:0];
      readback = 32'(value[wad_pkg::LIMIT_W-1:0]);
    end
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== readback) begin
      failed = 1'b1;
      $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
               $time, reg_idx, readback, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_words.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // rest and walking stretches around the zero-g level, with raw noise mixed in
  task automatic queue_activity(input int n_items);
    int amp;
    int seg;
    while (n_items > 0) begin
      case ($urandom_range(3, 0))
        0: amp = 3;
        1: amp = 40;
        2: amp = 350;
        default: amp = SAMPLE_MAX;
      endcase
      seg = $urandom_range(120, 10);
      for (int k = 0; k < seg && n_items > 0; k++) begin
        if ($urandom_range(9, 0) == 0)
          sample_words.push_back($urandom);
        else
          sample_words.push_back(pack_sample(near_zero_g(amp), near_zero_g(amp),
                                             near_zero_g(amp)));
        n_items--;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values of the registers
    sample_words.push_back(pack_sample(0, 0, 0));
    sample_words.push_back(pack_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
    sample_words.push_back(pack_sample(SAMPLE_MAX, 0, 0));
    sample_words.push_back({2'b11, 10'h2AA, 10'h155, 10'h3FF});
    wait_drained();

    // bits above the register widths are set too
    cfg_write(wad_pkg::REG_ZERO_G, 32'hFFFF_FC00 | 32'd512);
    cfg_write(wad_pkg::REG_SPREAD_LIMIT, 32'hFFC0_0000 | 32'd1000);
    sample_words.push_back(pack_sample(0, 0, 0));
    sample_words.push_back(pack_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
    sample_words.push_back(pack_sample(512, 512, 512));
    sample_words.push_back(pack_sample(0, SAMPLE_MAX, 512));
    sample_words.push_back(pack_sample(SAMPLE_MAX, 0, 512));
    sample_words.push_back(pack_sample(511, 513, 0));
    sample_words.push_back(pack_sample(513, 511, SAMPLE_MAX));
    sample_words.push_back(pack_sample(10'h155, 10'h2AA, 10'h155));
    sample_words.push_back(pack_sample(10'h2AA, 10'h155, 10'h2AA));
    sample_words.push_back({2'b10, 10'd512, 10'd0, 10'd1});
    sample_words.push_back({2'b01, 10'd1, 10'd1022, 10'd512});
    sample_words.push_back(pack_sample(512, 512, 512));
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          sink_stall_pct = 0;
          cfg_write(wad_pkg::REG_ZERO_G, 32'd0);
          cfg_write(wad_pkg::REG_SPREAD_LIMIT, 32'd0);
        end
        1: begin
          send_idle_pct = 63;
          sink_stall_pct = 0;
          cfg_write(wad_pkg::REG_ZERO_G, 32'd1023);
          cfg_write(wad_pkg::REG_SPREAD_LIMIT, 32'd4194303);
        end
        2: begin
          send_idle_pct = 0;
          sink_stall_pct = 63;
          cfg_write(wad_pkg::REG_ZERO_G, $urandom_range(900, 100));
          cfg_write(wad_pkg::REG_SPREAD_LIMIT, $urandom_range(60000, 100));
        end
        default: begin
          send_idle_pct = 34;
          sink_stall_pct = 34;
          cfg_write(wad_pkg::REG_ZERO_G, $urandom);
          cfg_write(wad_pkg::REG_SPREAD_LIMIT,
                    ($urandom & 32'hFFC0_0000) | $urandom_range(20000, 50));
        end
      endcase
      queue_activity(260);
      wait_drained();
    end

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
